### hdl/lug_pkg.sv
`timescale 1ns / 1ps

package lug_pkg;

    // Draw width and derived widths
    localparam int DRAW_BITS = 10;
    localparam int SPAN_W    = DRAW_BITS + 1;
    localparam int RANGE_W   = 11;
    localparam int OUT_W     = 10;
    localparam int CMP_W     = (SPAN_W > RANGE_W) ? SPAN_W : RANGE_W;
    localparam int OUT_CAT_W = (DRAW_BITS > OUT_W) ? DRAW_BITS : OUT_W;
    localparam int SHIFT_CNT_W = $clog2(DRAW_BITS + 1);
    localparam int DIV_CNT_W   = $clog2(SPAN_W + 1);

    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] TAP_MASK   = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

    localparam logic [SPAN_W-1:0]  SPAN        = SPAN_W'(1) << DRAW_BITS;
    localparam logic [RANGE_W-1:0] BOUND_MAX   = 11'd1024;
    localparam logic [RANGE_W-1:0] BOUND_MIN   = 11'd1;
    localparam logic [15:0]        RETRY_LIMIT = 16'hFFFF;

    localparam logic [5:0] K_HOURS_PER_DAY = 6'd24;
    localparam logic [5:0] K_SIXTY         = 6'd60;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } lfsr_ctrl_t;

    typedef struct packed {
        logic              en;
        logic [LFSR_W-1:0] a;
        logic [5:0]        k;
        logic [LFSR_W-1:0] b;
    } mac_req_t;

    typedef struct packed {
        logic              start;
        logic [SPAN_W-1:0] dividend;
        logic [SPAN_W-1:0] divisor;
    } mod_req_t;

    // seconds / 10 by reciprocal multiply, exact for any 6-bit value
    function automatic logic [2:0] div10_sec(input logic [5:0] sec);
        logic [13:0] p;
        p = 14'(sec) * 14'd205;
        return p[13:11];
    endfunction

endpackage

### hdl/lfsr_uniform_int_generator.sv
`timescale 1ns / 1ps

// Uniform random integer generator on a 16-bit Galois LFSR (taps 0xB400).
// A seed transaction (s_tuser = 0) loads the LFSR from calendar time,
// second/10 + 60*(minute + 60*(hour + 24*day_of_month)) kept to 16 bits,
// with a zero seed replaced by 1; it returns nothing and builds the seed in
// three passes through the shared multiply-add. A draw transaction
// (s_tuser = 1) shifts out 10 LFSR bits MSB-first, rejects values below
// 1024 mod range_max, and returns value mod range_max on m_tdata. Both
// remainders go through one shared bit-serial modulo unit, 11 steps each,
// and each rejected value is replaced by a fresh shift of 10 bits, up to
// the retry limit. s_tready is low while an item is in work; a finished
// result waits in the output register, and the next item is accepted
// meanwhile. range_max is written through cfg_we / cfg_data, clamped to
// 1..1024, and resets to 1024; the user must write it only while the
// block is idle, which the block itself does not enforce.

module lfsr_uniform_int_generator
    import lug_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RANGE_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month
    input  logic [23:0]        s_tdata,
    // [0] opcode
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [9:0] random_value
    output logic [15:0]        m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_SEED_C,
        ST_SEED_LOAD,
        ST_DRAW_INIT,
        ST_LOW_START,
        ST_LOW_WAIT,
        ST_SHIFT,
        ST_CHECK,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [RANGE_W-1:0]     range_reg, range_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;
    logic [SHIFT_CNT_W-1:0] shift_cnt_reg, shift_cnt_next;
    logic [15:0]            tries_reg, tries_next;

    logic [5:0]            sec_reg, sec_next;
    logic [5:0]            min_reg, min_next;
    logic [4:0]            hour_reg, hour_next;
    logic [4:0]            day_reg, day_next;
    logic [SPAN_W-1:0]     bound_reg, bound_next;
    logic [DRAW_BITS-1:0]  low_reg, low_next;
    logic [DRAW_BITS-1:0]  val_reg, val_next;

    lfsr_ctrl_t           lfsr_ctrl;
    logic [LFSR_W-1:0]    lfsr_seed;
    logic                 lfsr_bit;
    logic [LFSR_W-1:0]    lfsr_state;
    mac_req_t             mac_req;
    logic [LFSR_W-1:0]    mac_acc;
    mod_req_t             mod_req;
    logic                 mod_busy;
    logic                 mod_done;
    logic [DRAW_BITS-1:0] mod_rem;

    logic [CMP_W-1:0]     range_ext;
    logic [OUT_CAT_W-1:0] out_ext;
    logic                 out_load;
    logic                 in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    assign range_ext = CMP_W'(range_reg);
    assign out_ext   = OUT_CAT_W'(mod_rem);

    lug_lfsr u_lfsr (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lfsr_ctrl),
        .seed    (lfsr_seed),
        .bit_out (lfsr_bit),
        .state   (lfsr_state)
    );

    lug_seed_mac u_mac (
        .clk (clk),
        .req (mac_req),
        .acc (mac_acc)
    );

    lug_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Drive the shared units from the sequencer state
    always_comb
    begin
        lfsr_ctrl.load = (state_reg == ST_SEED_LOAD);
        lfsr_ctrl.step = (state_reg == ST_SHIFT);
        lfsr_seed      = (mac_acc == '0) ? LFSR_W'(1) : mac_acc;

        mac_req.en = 1'b0;
        mac_req.a  = mac_acc;
        mac_req.k  = K_SIXTY;
        mac_req.b  = '0;
        case (state_reg)
            ST_SEED_A:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = LFSR_W'(day_reg);
                mac_req.k  = K_HOURS_PER_DAY;
                mac_req.b  = LFSR_W'(hour_reg);
            end
            ST_SEED_B:
            begin
                mac_req.en = 1'b1;
                mac_req.b  = LFSR_W'(min_reg);
            end
            ST_SEED_C:
            begin
                mac_req.en = 1'b1;
                mac_req.b  = LFSR_W'(div10_sec(sec_reg));
            end
            default:
            begin
                mac_req.en = 1'b0;
            end
        endcase

        // span mod bound first, then value mod bound
        mod_req.start    = (state_reg == ST_LOW_START) || (state_reg == ST_MOD_START);
        mod_req.dividend = (state_reg == ST_LOW_START) ? SPAN : SPAN_W'(val_reg);
        mod_req.divisor  = bound_reg;
    end

    // Sequencer and registered outputs
    always_comb
    begin
        state_next     = state_reg;
        range_next     = range_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        shift_cnt_next = shift_cnt_reg;
        tries_next     = tries_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        bound_next     = bound_reg;
        low_next       = low_reg;
        val_next       = val_reg;

        // clamp register writes to 1..1024
        if (cfg_we)
        begin
            if (cfg_data < BOUND_MIN)
            begin
                range_next = BOUND_MIN;
            end
            else if (cfg_data > BOUND_MAX)
            begin
                range_next = BOUND_MAX;
            end
            else
            begin
                range_next = cfg_data;
            end
        end

        // drop the result once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sec_next   = s_tdata[5:0];
                    min_next   = s_tdata[11:6];
                    hour_next  = s_tdata[16:12];
                    day_next   = s_tdata[21:17];
                    state_next = (s_tuser == OP_DRAW) ? ST_DRAW_INIT : ST_SEED_A;
                end
            end
            ST_SEED_A:
            begin
                state_next = ST_SEED_B;
            end
            ST_SEED_B:
            begin
                state_next = ST_SEED_C;
            end
            ST_SEED_C:
            begin
                state_next = ST_SEED_LOAD;
            end
            ST_SEED_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_DRAW_INIT:
            begin
                // bound never exceeds the draw span
                bound_next = (range_ext < CMP_W'(SPAN)) ? SPAN_W'(range_ext) : SPAN;
                tries_next = '0;
                state_next = ST_LOW_START;
            end
            ST_LOW_START:
            begin
                state_next = ST_LOW_WAIT;
            end
            ST_LOW_WAIT:
            begin
                if (mod_done)
                begin
                    low_next       = mod_rem;
                    shift_cnt_next = '0;
                    val_next       = '0;
                    state_next     = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                val_next = (val_reg << 1) | DRAW_BITS'(lfsr_bit);
                if (shift_cnt_reg == SHIFT_CNT_W'(DRAW_BITS - 1))
                begin
                    tries_next = tries_reg + 16'd1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    shift_cnt_next = shift_cnt_reg + SHIFT_CNT_W'(1);
                end
            end
            ST_CHECK:
            begin
                // reject values in the short tail, up to the retry limit
                if ((val_reg < low_reg) && (tries_reg != RETRY_LIMIT))
                begin
                    shift_cnt_next = '0;
                    val_next       = '0;
                    state_next     = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_MOD_START;
                end
            end
            ST_MOD_START:
            begin
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = out_ext[OUT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            range_reg     <= BOUND_MAX;
            m_valid_reg   <= 1'b0;
            shift_cnt_reg <= '0;
            tries_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            range_reg     <= range_next;
            m_valid_reg   <= m_valid_next;
            shift_cnt_reg <= shift_cnt_next;
            tries_reg     <= tries_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        day_reg    <= day_next;
        bound_reg  <= bound_next;
        low_reg    <= low_next;
        val_reg    <= val_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 16'(m_data_reg);

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> !s_tready)
        else $error("input accepted while modulo unit busy");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_state != '0)
        else $error("LFSR reached the all-zero state");

    a_result_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (SPAN_W'(mod_rem) < bound_reg))
        else $error("result not below bound");

    a_range_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (range_reg >= BOUND_MIN) && (range_reg <= BOUND_MAX))
        else $error("range_max outside 1..1024");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> ((state_reg == ST_LOW_WAIT) || (state_reg == ST_MOD_WAIT)))
        else $error("modulo result arrived outside a wait state");
`endif

endmodule

### hdl/lug_lfsr.sv
`timescale 1ns / 1ps

module lug_lfsr
    import lug_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lfsr_ctrl_t        ctrl,
    input  logic [LFSR_W-1:0] seed,
    output logic              bit_out,
    output logic [LFSR_W-1:0] state
);

    logic [LFSR_W-1:0] state_reg;
    logic [LFSR_W-1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load)
        begin
            state_next = seed;
        end
        else if (ctrl.step)
        begin
            state_next = (state_reg >> 1) ^ (state_reg[0] ? TAP_MASK : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LFSR_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign bit_out = state_reg[0];
    assign state   = state_reg;

endmodule

### hdl/lug_seed_mac.sv
`timescale 1ns / 1ps

module lug_seed_mac
    import lug_pkg::*;
(
    input  logic              clk,
    input  mac_req_t          req,
    output logic [LFSR_W-1:0] acc
);

    logic [LFSR_W-1:0] acc_reg;
    logic [LFSR_W-1:0] acc_next;
    logic [LFSR_W+6:0] sum;

    // keep the low 16 bits only; the seed is taken mod 2^16 anyway
    always_comb
    begin
        sum      = (23'(req.a) * 23'(req.k)) + 23'(req.b);
        acc_next = req.en ? sum[LFSR_W-1:0] : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

### hdl/lug_mod_unit.sv
`timescale 1ns / 1ps

module lug_mod_unit
    import lug_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mod_req_t             req,
    output logic                 busy,
    output logic                 done,
    output logic [DRAW_BITS-1:0] remainder
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DRAW_BITS-1:0] rem_reg, rem_next;
    logic [SPAN_W-1:0]    dvd_reg, dvd_next;
    logic [SPAN_W-1:0]    dvs_reg, dvs_next;
    logic [SPAN_W-1:0]    cand;
    logic [SPAN_W-1:0]    diff;

    // one restoring step per cycle, MSB of the dividend first
    always_comb
    begin
        cand      = {rem_reg, dvd_reg[SPAN_W-1]};
        diff      = cand - dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            cnt_next = DIV_CNT_W'(SPAN_W);
            rem_next = '0;
            dvd_next = req.dividend;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = (cand >= dvs_reg) ? diff[DRAW_BITS-1:0] : cand[DRAW_BITS-1:0];
            dvd_next  = dvd_reg << 1;
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lug_pkg::*;

    // Run length and pacing
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 80;    // covers a seed still in work after the last result
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_REPORTS  = 10;

    // One input transaction, fields as the block sees them
    typedef struct packed {
        logic       op;
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] mday;
    } calendar_item_t;

    // DUT connections; the DUT inputs are driven to known values from time zero
    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [RANGE_W-1:0] cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;

    // Predictor state: LFSR contents and the clamped bound
    logic [LFSR_W-1:0]  lfsr_state  = LFSR_RESET;
    logic [RANGE_W-1:0] range_bound = BOUND_MAX;

    calendar_item_t pending_items[$];
    logic [9:0]     expected_values[$];
    calendar_item_t cur_item;

    bit in_flight      = 1'b0;
    bit sender_steady  = 1'b0;
    bit sink_steady    = 1'b0;
    bit hold_request   = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int report_count   = 0;
    int seed_count     = 0;
    int draw_count     = 0;
    int checked_count  = 0;
    int setting_count  = 0;

    lfsr_uniform_int_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Seed value from calendar time, kept to 16 bits, zero replaced by one
    function automatic logic [LFSR_W-1:0] seed_from_time(calendar_item_t it);
        logic [31:0] s;
        s = 32'(it.sec) / 32'd10
            + 32'd60 * (32'(it.minute) + 32'd60 * (32'(it.hour) + 32'd24 * 32'(it.mday)));
        if (s[15:0] == 16'd0)
            return LFSR_RESET;
        return s[15:0];
    endfunction

    // Shift out DRAW_BITS bits MSB-first, reject below span mod bound, reduce
    task automatic draw_uniform(output logic [9:0] value);
        logic [RANGE_W-1:0] bnd;
        logic [RANGE_W-1:0] low;
        logic [15:0]        v;
        logic               b;
        int                 tries;
        bnd = range_bound;
        if (bnd > SPAN)
            bnd = SPAN;
        if (bnd == '0)
            bnd = BOUND_MIN;
        low   = RANGE_W'(32'(SPAN) % 32'(bnd));
        tries = 0;
        do
        begin
            v = '0;
            for (int i = 0; i < DRAW_BITS; i++)
            begin
                b          = lfsr_state[0];
                lfsr_state = (lfsr_state >> 1) ^ (b ? TAP_MASK : '0);
                v          = {v[14:0], b};
            end
            tries++;
        end
        while (32'(v) < 32'(low) && tries < 32'(RETRY_LIMIT));
        value = 10'(32'(v) % 32'(bnd));
    endtask

    // Update the predictor for one accepted transaction
    task automatic predict_transaction(calendar_item_t it);
        logic [9:0] value;
        if (it.op == OP_SEED)
        begin
            lfsr_state = seed_from_time(it);
            seed_count++;
        end
        else
        begin
            draw_uniform(value);
            expected_values.push_back(value);
            draw_count++;
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        error_count++;
        if (report_count < MAX_REPORTS)
        begin
            report_count++;
            $display("[%0t] %s: expected random_value 0x%03h, got m_tdata 0x%04h",
                     $realtime, what, want, got);
        end
    endtask

    // Sender: commit the predictor at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_transaction(cur_item);
            in_flight = 1'b0;
        end
    end

    // Sender: present the next pending item at the falling edge, hold it until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!in_flight)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                s_tdata  <= {2'b00, cur_item.mday, cur_item.hour, cur_item.minute,
                             cur_item.sec};
                s_tuser  <= cur_item.op;
                s_tvalid <= 1'b1;
                in_flight = 1'b1;
                send_gap  = sender_steady ? 0 : pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (sink_steady)
            m_tready <= 1'b1;
        else
        begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
        end
    end

    // Monitor: compare each result transaction with the oldest expected value
    always @(posedge clk)
    begin : check_results
        logic [9:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
                report_mismatch("unexpected result", 16'h0000, m_tdata);
            else
            begin
                want = expected_values.pop_front();
                checked_count++;
                if (m_tdata !== {6'b000000, want})
                    report_mismatch("result mismatch", {6'b000000, want}, m_tdata);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_values.size());
            $display("** lfsr_uniform_int_generator: FAILED **");
            $finish;
        end
    end

    task automatic push_seed(int sec, int minute, int hour, int mday);
        calendar_item_t it;
        it.op     = OP_SEED;
        it.sec    = 6'(sec);
        it.minute = 6'(minute);
        it.hour   = 5'(hour);
        it.mday   = 5'(mday);
        pending_items.push_back(it);
    endtask

    // Draws carry random time fields; the block must ignore them
    task automatic push_draws(int n);
        calendar_item_t it;
        repeat (n)
        begin
            it    = calendar_item_t'(23'($urandom));
            it.op = OP_DRAW;
            pending_items.push_back(it);
        end
    endtask

    task automatic push_random_seed();
        if ($urandom_range(0, 1))
            push_seed($urandom_range(0, 60), $urandom_range(0, 59),
                      $urandom_range(0, 23), $urandom_range(1, 31));
        else
            push_seed($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 31), $urandom_range(0, 31));
    endtask

    // Block until the sender is empty and every result is in, then let a seed finish
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_flight || expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Write range_max while idle and track the clamped value
    task automatic write_range(logic [RANGE_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        if (value < BOUND_MIN)
            range_bound = BOUND_MIN;
        else if (value > BOUND_MAX)
            range_bound = BOUND_MAX;
        else
            range_bound = value;
        setting_count++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [RANGE_W-1:0] settings[$];
        int                 phase;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: draws from the reset state and bound, then seeds at the corners
        push_draws(3);
        push_seed(0, 0, 0, 0);      // zero seed, replaced by one
        push_draws(1);
        push_seed(40, 49, 0, 3);    // sum wraps to exactly zero in 16 bits
        push_draws(1);
        push_seed(63, 63, 31, 31);  // every field at its full width
        push_draws(2);
        push_seed(60, 59, 23, 31);  // in-range maximum
        push_draws(1);
        push_seed(0, 0, 0, 1);      // in-range minimum
        push_draws(1);
        push_seed(9, 0, 0, 0);
        push_seed(59, 12, 7, 15);   // back-to-back seeds, the last one wins
        push_draws(2);
        wait_drained();

        // Directed: bound extremes, including the clamps on both sides
        write_range(11'd1);
        push_draws(2);
        wait_drained();
        write_range(11'd0);
        push_draws(2);
        wait_drained();
        write_range(11'd2047);
        push_seed(30, 30, 12, 16);
        push_draws(2);
        wait_drained();
        write_range(11'd1025);
        push_draws(1);
        wait_drained();

        // Random phases over several bounds; 513 rejects almost half of all values
        settings = '{11'd513, 11'd1, 11'd1024, 11'd3, 11'd1000, 11'd2047,
                     11'd0, 11'd700, 11'd1023, 11'd512,
                     11'($urandom_range(0, 2047)), 11'($urandom_range(1, 1024))};
        for (phase = 0; phase < settings.size(); phase++)
        begin
            write_range(settings[phase]);
            sender_steady = (phase % 4 == 1);
            sink_steady   = (phase % 4 == 2);
            // Starve the output while items keep coming so the block backs up
            if (phase == 2 || phase == 7)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_random_seed();
                else
                    push_draws(1);
                // Halfway through, pause the sender until every result is back
                if (i == PHASE_ITEMS / 2)
                begin
                    while (pending_items.size() != 0 || in_flight
                           || expected_values.size() != 0)
                        @(posedge clk);
                end
            end
            wait_drained();
        end

        $display("covered %0d seeds and %0d draws over %0d bound settings;",
                 seed_count, draw_count, setting_count);
        $display("checked %0d results, %0d failures, %0d cycles",
                 checked_count, error_count, cycle_count);
        if (error_count == 0 && expected_values.size() == 0)
            $display("** lfsr_uniform_int_generator: PASSED **");
        else
            $display("** lfsr_uniform_int_generator: FAILED **");
        $finish;
    end

endmodule

### sim.f
hdl/lug_pkg.sv
hdl/lug_lfsr.sv
hdl/lug_seed_mac.sv
hdl/lug_mod_unit.sv
hdl/lfsr_uniform_int_generator.sv
dv/testbench.sv
